[rtl/dq_pkg.sv]
// Shared constants, command and status codes, and types for the double-ended queue.
`default_nettype none

package dq_pkg;

  // Store geometry. DEPTH is a power of two between 2 and 256.
  localparam int DEPTH      = 256;
  localparam int WORD_WIDTH = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed widths of the port fields.
  localparam int CMD_W    = 4;
  localparam int DATA_W   = 64;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Command codes carried on the input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_AT_BACK = 4'd0,
    CMD_PUSH_FRONT   = 4'd1,
    CMD_POP_BACK     = 4'd2,
    CMD_POP_AT_FRONT = 4'd3,
    CMD_READ_BACK    = 4'd4,
    CMD_READ_FRONT   = 4'd5,
    CMD_READ_INDEX   = 4'd6,
    CMD_WRITE_INDEX  = 4'd7,
    CMD_CLEAR        = 4'd8
  } dq_cmd_code_t;

  // Status codes returned on the result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } dq_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } dq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } dq_ctl_t;

endpackage

`default_nettype wire

[rtl/dq_ctrl.sv]
// Controller state machine that sequences capture, execution and result of each command.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  output dq_ctl_t      ctl
);

  dq_state_t state;
  dq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: take a beat, run it once, then hold the result until it is taken.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs decoded from the state; in_stall and out_valid use the state alone, so valid never follows stall.
  always_comb begin
    in_stall    = (state != S_IDLE);
    out_valid   = (state == S_RESP);
    ctl.capture = (state == S_IDLE) && in_valid;
    ctl.execute = (state == S_EXEC);
  end

endmodule

`default_nettype wire

[rtl/dq_datapath.sv]
// Datapath: entry store, head pointer, entry count and result registers.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dq_ctl_t             ctl,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic [DATA_W-1:0]   value,
  input  wire logic [POS_W-1:0]    position,
  output logic      [DATA_W-1:0]   data,
  output logic      [STATUS_W-1:0] status,
  output logic      [COUNT_W-1:0]  count,
  output logic                     is_empty
);

  // Captured command beat.
  dq_cmd_code_t          cmd_q;
  logic [WORD_WIDTH-1:0] value_q;
  logic [POS_W-1:0]      pos_q;

  // Queue state.
  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;

  // Entry store and its registered read port.
  logic [WORD_WIDTH-1:0] mem [DEPTH];
  logic [WORD_WIDTH-1:0] rd_q;

  // Result registers.
  dq_status_t status_q;
  dq_status_t status_next;
  logic       use_rd_q;
  logic       use_rd_next;

  // Per-command decode.
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W-1:0] slot;
  logic              q_empty;
  logic              q_full;

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= dq_cmd_code_t'(command);
      value_q <= value[WORD_WIDTH-1:0];
      pos_q   <= position;
    end
  end

  // Slot of an entry counted from the front, wrapped around the ring.
  always_comb begin
    slot_sum = {1'b0, head} + {1'b0, offset};
    if (slot_sum >= (ADDR_W + 1)'(DEPTH)) begin
      slot_sum = slot_sum - (ADDR_W + 1)'(DEPTH);
    end
    slot = slot_sum[ADDR_W-1:0];
  end

  assign q_empty = (cnt == '0);
  assign q_full  = (cnt == CNT_W'(DEPTH));

  // Decode the captured command against the current head and count.
  always_comb begin
    offset      = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    head_next   = head;
    cnt_next    = cnt;
    status_next = ST_OK;
    use_rd_next = 1'b0;
    unique case (cmd_q)
      CMD_PUSH_AT_BACK: begin
        if (q_full) begin
          status_next = ST_FULL;
        end else begin
          offset   = cnt[ADDR_W-1:0];
          mem_we   = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (q_full) begin
          status_next = ST_FULL;
        end else begin
          offset    = ADDR_W'(DEPTH - 1);
          mem_we    = 1'b1;
          head_next = slot;
          cnt_next  = cnt + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (q_empty) begin
          status_next = ST_EMPTY;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      CMD_POP_AT_FRONT: begin
        if (q_empty) begin
          status_next = ST_EMPTY;
        end else begin
          offset    = ADDR_W'(1);
          head_next = slot;
          cnt_next  = cnt - CNT_W'(1);
        end
      end
      CMD_READ_BACK: begin
        if (q_empty) begin
          status_next = ST_EMPTY;
        end else begin
          offset      = ADDR_W'(cnt - CNT_W'(1));
          mem_re      = 1'b1;
          use_rd_next = 1'b1;
        end
      end
      CMD_READ_FRONT: begin
        if (q_empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_re      = 1'b1;
          use_rd_next = 1'b1;
        end
      end
      CMD_READ_INDEX: begin
        if (CNT_W'(pos_q) >= cnt) begin
          status_next = ST_RANGE;
        end else begin
          offset      = ADDR_W'(pos_q);
          mem_re      = 1'b1;
          use_rd_next = 1'b1;
        end
      end
      CMD_WRITE_INDEX: begin
        if (CNT_W'(pos_q) >= cnt) begin
          status_next = ST_RANGE;
        end else begin
          offset = ADDR_W'(pos_q);
          mem_we = 1'b1;
        end
      end
      CMD_CLEAR: begin
        head_next = '0;
        cnt_next  = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Entry store: one write or one registered read per command.
  always_ff @(posedge clk) begin
    if (ctl.execute && mem_we) begin
      mem[slot] <= value_q;
    end
    if (ctl.execute && mem_re) begin
      rd_q <= mem[slot];
    end
  end

  // Head pointer and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
    end else if (ctl.execute) begin
      head <= head_next;
      cnt  <= cnt_next;
    end
  end

  // Result status and data select.
  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status_q <= status_next;
      use_rd_q <= use_rd_next;
    end
  end

  // Result beat fields.
  assign data     = use_rd_q ? DATA_W'(rd_q) : '0;
  assign status   = status_q;
  assign count    = COUNT_W'(cnt);
  assign is_empty = q_empty;

endmodule

`default_nettype wire

[rtl/double_ended_queue.sv]
// Top level of the double-ended queue: controller and datapath.
`default_nettype none

// Bounded double-ended queue of 64-bit words held in a 256-entry ring with a
// head pointer and a count. Each input beat carries one command (push or pop
// at either end, read front or back, read or write at an index from the
// front, or clear) and yields exactly one result beat with data, status, the
// count after the command and an empty flag. Commands run one at a time: the
// cycle after a beat is accepted runs it with one access to the single-port
// entry store, and the cycle after that offers the registered result, which
// is held while the output is stalled. The next beat is taken in the cycle
// after the result beat leaves, so a new command is not accepted before the
// last one's result has left. The store is not cleared at reset; only
// entries that were pushed or written are ever read back.
module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    command,
  input  wire logic [DATA_W-1:0]   value,
  input  wire logic [POS_W-1:0]    position,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [DATA_W-1:0]   data,
  output logic      [STATUS_W-1:0] status,
  output logic      [COUNT_W-1:0]  count,
  output logic                     is_empty
);

  dq_ctl_t ctl;

  // Sequencing of each command.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // Storage, pointers and result registers.
  dq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .command  (command),
    .value    (value),
    .position (position),
    .data     (data),
    .status   (status),
    .count    (count),
    .is_empty (is_empty)
  );

endmodule

`default_nettype wire
